// ===== sv/parl_pkg.sv =====
// Shared constants, enums and the command/status bundles of the arc-length resampler.
// No dependencies; every other file imports this package.
`default_nettype none

package parl_pkg;

    localparam int IO_W            = 32;
    localparam int LEN_W           = 48;
    localparam int OC_W            = 7;
    localparam int MAX_POINTS_DEF  = 256;
    localparam int MAX_OUTPUTS_DEF = 64;
    localparam int COORD_WIDTH_DEF = 32;
    localparam logic [OC_W-1:0] OC_RESET = OC_W'(2);

    typedef enum logic [1:0] {
        COORD_X = 2'd0,
        COORD_Y = 2'd1,
        COORD_Z = 2'd2
    } coord_t;

    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_ONE  = 2'd1,
        RD_NEXT = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        RES_HOLD  = 2'd0,
        RES_FIRST = 2'd1,
        RES_LAST  = 2'd2,
        RES_LO    = 2'd3
    } res_sel_t;

    typedef struct packed {
        logic     in_ready;
        logic     accept;
        logic     sq_mul;
        logic     sum_clear;
        logic     sum_add;
        coord_t   sq_sel;
        logic     root_load;
        logic     root_step;
        logic     len_write;
        logic     emit_start;
        rd_sel_t  rd_sel;
        logic     lo_load;
        logic     hi_load;
        logic     advance;
        logic     tdiv_load;
        logic     div_step;
        logic     lerp_load;
        logic     mul_load;
        logic     mul_step;
        logic     ldiv_load;
        logic     coord_store;
        res_sel_t res_sel;
        logic     put;
        logic     run_end;
    } ctl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic full;
        logic count_zero;
        logic last_held;
        logic step_last;
        logic k_zero;
        logic k_last;
        logic n_one;
        logic can_advance;
        logic seg_zero;
        logic coord_last;
        logic slot_free;
    } ctl_status_t;

endpackage

`default_nettype wire

// ===== sv/parl_point_if.sv =====
// Input channel carrying one polyline point per item.
// Depends on parl_pkg for the coordinate width.
`default_nettype none

interface parl_point_if import parl_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic signed [IO_W-1:0] point_x;
    logic signed [IO_W-1:0] point_y;
    logic signed [IO_W-1:0] point_z;
    logic                   last_point;

    modport source (output valid, point_x, point_y, point_z, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

`default_nettype wire

// ===== sv/parl_result_if.sv =====
// Output channel carrying one resampled point per item.
// Depends on parl_pkg for the coordinate width.
`default_nettype none

interface parl_result_if import parl_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic signed [IO_W-1:0] out_x;
    logic signed [IO_W-1:0] out_y;
    logic signed [IO_W-1:0] out_z;
    logic                   out_last;
    logic                   overflow_flag;

    modport source (output valid, out_x, out_y, out_z, out_last, overflow_flag, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_last, overflow_flag, output ready);
endinterface

`default_nettype wire

// ===== sv/parl_cfg_if.sv =====
// Configuration write channel for the output point count.
// Depends on parl_pkg for the register width.
`default_nettype none

interface parl_cfg_if import parl_pkg::*;;
    logic            valid;
    logic            ready;
    logic [OC_W-1:0] output_count;

    modport source (output valid, output_count, input ready);
    modport sink   (input valid, output_count, output ready);
endinterface

`default_nettype wire

// ===== sv/parl_ctrl.sv =====
// Sequencer of the resampler: one-hot state machine issuing datapath commands.
// Depends on parl_pkg for the command and status bundles.
`default_nettype none

module parl_ctrl import parl_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  ctl_status_t      status,
    output ctl_cmd_t         cmd
);

    localparam int ST_W = 22;

    typedef enum logic [ST_W-1:0] {
        S_IDLE  = ST_W'(1) << 0,
        S_SQ0   = ST_W'(1) << 1,
        S_SQ1   = ST_W'(1) << 2,
        S_SQ2   = ST_W'(1) << 3,
        S_SQ3   = ST_W'(1) << 4,
        S_RLOAD = ST_W'(1) << 5,
        S_ROOT  = ST_W'(1) << 6,
        S_LEN   = ST_W'(1) << 7,
        S_EPREP = ST_W'(1) << 8,
        S_INIT1 = ST_W'(1) << 9,
        S_INIT2 = ST_W'(1) << 10,
        S_PICK  = ST_W'(1) << 11,
        S_TLOAD = ST_W'(1) << 12,
        S_TDIV  = ST_W'(1) << 13,
        S_SRCH  = ST_W'(1) << 14,
        S_SLD   = ST_W'(1) << 15,
        S_MLOAD = ST_W'(1) << 16,
        S_MUL   = ST_W'(1) << 17,
        S_DLOAD = ST_W'(1) << 18,
        S_DIV   = ST_W'(1) << 19,
        S_CST   = ST_W'(1) << 20,
        S_PUT   = ST_W'(1) << 21
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.full)
                    begin
                        state_next = status.in_last ? S_EPREP : S_IDLE;
                    end
                    else if (status.count_zero)
                    begin
                        state_next = S_LEN;
                    end
                    else
                    begin
                        state_next = S_SQ0;
                    end
                end
            end
            S_SQ0:
            begin
                cmd.sq_mul    = 1'b1;
                cmd.sq_sel    = COORD_X;
                cmd.sum_clear = 1'b1;
                state_next    = S_SQ1;
            end
            S_SQ1:
            begin
                cmd.sq_mul  = 1'b1;
                cmd.sq_sel  = COORD_Y;
                cmd.sum_add = 1'b1;
                state_next  = S_SQ2;
            end
            S_SQ2:
            begin
                cmd.sq_mul  = 1'b1;
                cmd.sq_sel  = COORD_Z;
                cmd.sum_add = 1'b1;
                state_next  = S_SQ3;
            end
            S_SQ3:
            begin
                cmd.sum_add = 1'b1;
                state_next  = S_RLOAD;
            end
            S_RLOAD:
            begin
                cmd.root_load = 1'b1;
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.step_last)
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                cmd.len_write = 1'b1;
                state_next    = status.last_held ? S_EPREP : S_IDLE;
            end
            S_EPREP:
            begin
                cmd.emit_start = 1'b1;
                cmd.rd_sel     = RD_ZERO;
                state_next     = S_INIT1;
            end
            S_INIT1:
            begin
                cmd.lo_load = 1'b1;
                cmd.rd_sel  = RD_ONE;
                state_next  = S_INIT2;
            end
            S_INIT2:
            begin
                cmd.hi_load = 1'b1;
                state_next  = S_PICK;
            end
            S_PICK:
            begin
                if (status.k_zero || status.n_one)
                begin
                    cmd.res_sel = RES_FIRST;
                    state_next  = S_PUT;
                end
                else if (status.k_last)
                begin
                    cmd.res_sel = RES_LAST;
                    state_next  = S_PUT;
                end
                else
                begin
                    state_next = S_TLOAD;
                end
            end
            S_TLOAD:
            begin
                cmd.tdiv_load = 1'b1;
                state_next    = S_TDIV;
            end
            S_TDIV:
            begin
                cmd.div_step = 1'b1;
                if (status.step_last)
                begin
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (status.can_advance)
                begin
                    cmd.advance = 1'b1;
                    cmd.rd_sel  = RD_NEXT;
                    state_next  = S_SLD;
                end
                else
                begin
                    cmd.lerp_load = 1'b1;
                    if (status.seg_zero)
                    begin
                        cmd.res_sel = RES_LO;
                        state_next  = S_PUT;
                    end
                    else
                    begin
                        state_next = S_MLOAD;
                    end
                end
            end
            S_SLD:
            begin
                cmd.hi_load = 1'b1;
                state_next  = S_SRCH;
            end
            S_MLOAD:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (status.step_last)
                begin
                    state_next = S_DLOAD;
                end
            end
            S_DLOAD:
            begin
                cmd.ldiv_load = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.step_last)
                begin
                    state_next = S_CST;
                end
            end
            S_CST:
            begin
                cmd.coord_store = 1'b1;
                state_next      = status.coord_last ? S_PUT : S_MLOAD;
            end
            S_PUT:
            begin
                if (status.slot_free)
                begin
                    cmd.put = 1'b1;
                    if (status.k_last)
                    begin
                        cmd.run_end = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PICK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/parl_dpath.sv =====
// Datapath of the resampler: point and length stores, square/root unit, shared
// shift-add multiplier and restoring divider, output register. Uses parl_pkg.
`default_nettype none

module parl_dpath import parl_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    parl_point_if.sink        points,
    parl_result_if.source     results,
    parl_cfg_if.sink          cfg,
    input  ctl_cmd_t          cmd,
    output ctl_status_t       status
);

    localparam int CW    = COORD_WIDTH;
    localparam int MW    = CW + 1;
    localparam int PW    = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int NW    = PW + 1;
    localparam int SH_W  = (MW > LEN_W) ? MW : LEN_W;
    localparam int CNT_W = $clog2(SH_W + 1);
    localparam int SQ_W  = 2 * MW;
    localparam int RM_W  = MW + 3;
    localparam int SUM_W = SH_W + 1;
    localparam int ACC_W = LEN_W + OC_W;
    localparam int P_W   = LEN_W + MW;
    localparam int SHT_T = SH_W - LEN_W;
    localparam int SHT_L = SH_W - MW;

    // stores
    logic signed [CW-1:0]    x_mem [MAX_POINTS];
    logic signed [CW-1:0]    y_mem [MAX_POINTS];
    logic signed [CW-1:0]    z_mem [MAX_POINTS];
    logic [LEN_W-1:0]        len_mem [MAX_POINTS];
    logic signed [CW-1:0]    rd_x_reg, rd_y_reg, rd_z_reg;
    logic [LEN_W-1:0]        rd_len_reg;

    // control state
    logic [NW-1:0]           count_reg;
    logic                    ovf_reg;
    logic                    last_reg;
    logic [OC_W-1:0]         oc_reg;
    logic [CNT_W-1:0]        step_reg;
    logic [OC_W-1:0]         k_reg;
    logic [OC_W-1:0]         cnt_reg;
    logic [PW-1:0]           idx_reg;
    coord_t                  c_reg;
    logic                    out_valid_reg;

    // payload
    logic signed [CW-1:0]    cur_x_reg, cur_y_reg, cur_z_reg;
    logic signed [CW-1:0]    prev_x_reg, prev_y_reg, prev_z_reg;
    logic signed [CW-1:0]    first_x_reg, first_y_reg, first_z_reg;
    logic [LEN_W-1:0]        prev_len_reg;
    logic [SQ_W-1:0]         prod_reg, sum_reg, rad_reg;
    logic [RM_W-1:0]         rrem_reg;
    logic [MW-1:0]           root_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic signed [CW-1:0]    lo_x_reg, lo_y_reg, lo_z_reg;
    logic signed [CW-1:0]    hi_x_reg, hi_y_reg, hi_z_reg;
    logic [LEN_W-1:0]        lo_len_reg, hi_len_reg;
    logic [LEN_W-1:0]        num_reg, den_reg, dvsr_reg, drem_reg;
    logic [SH_W-1:0]         dsh_reg;
    logic [P_W-1:0]          prd_reg;
    logic signed [CW-1:0]    res_x_reg, res_y_reg, res_z_reg;
    logic signed [IO_W-1:0]  out_x_reg, out_y_reg, out_z_reg;
    logic                    out_last_reg, out_ovf_reg;

    // combinational
    logic                    full;
    logic [PW-1:0]           wr_addr, rd_addr;
    logic signed [CW-1:0]    sq_a, sq_b;
    logic signed [MW-1:0]    sq_diff;
    logic [MW-1:0]           sq_mag;
    logic [SQ_W-1:0]         sq_prod;
    logic [RM_W-1:0]         rrem_sh, rtrial;
    logic                    rge;
    logic [SUM_W-1:0]        lsum;
    logic [LEN_W-1:0]        new_len;
    logic [LEN_W:0]          dtrial;
    logic                    dge;
    logic [LEN_W-1:0]        tgt, tgt_off, seg_len;
    logic signed [CW-1:0]    lp_a, lp_b, lp_new;
    logic signed [MW-1:0]    lp_diff;
    logic [MW-1:0]           lp_mag;
    logic [LEN_W:0]          msum;
    logic [OC_W-1:0]         cnt_clamp;
    coord_t                  c_next;

    assign full    = (count_reg == NW'(MAX_POINTS));
    assign wr_addr = count_reg[PW-1:0];

    always_comb
    begin
        case (cmd.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_ONE:  rd_addr = PW'(1);
            RD_NEXT: rd_addr = PW'({1'b0, idx_reg} + NW'(2));
            default: rd_addr = '0;
        endcase
    end

    // segment length: square of each coordinate difference
    always_comb
    begin
        case (cmd.sq_sel)
            COORD_X: begin sq_a = cur_x_reg; sq_b = prev_x_reg; end
            COORD_Y: begin sq_a = cur_y_reg; sq_b = prev_y_reg; end
            COORD_Z: begin sq_a = cur_z_reg; sq_b = prev_z_reg; end
            default: begin sq_a = cur_x_reg; sq_b = prev_x_reg; end
        endcase
    end

    assign sq_diff = MW'(sq_a) - MW'(sq_b);
    assign sq_mag  = sq_diff[MW-1] ? MW'(-sq_diff) : MW'(sq_diff);
    assign sq_prod = SQ_W'(sq_mag) * SQ_W'(sq_mag);

    assign rrem_sh = {rrem_reg[RM_W-3:0], rad_reg[SQ_W-1 -: 2]};
    assign rtrial  = {1'b0, root_reg, 2'b01};
    assign rge     = (rrem_sh >= rtrial);

    assign lsum    = SUM_W'(prev_len_reg) + SUM_W'(root_reg);
    always_comb
    begin
        if (count_reg == '0)
        begin
            new_len = '0;
        end
        else if (lsum > SUM_W'({LEN_W{1'b1}}))
        begin
            new_len = {LEN_W{1'b1}};
        end
        else
        begin
            new_len = LEN_W'(lsum);
        end
    end

    // shared restoring divider, one quotient bit per cycle
    assign dtrial = {drem_reg, dsh_reg[SH_W-1]};
    assign dge    = (dtrial >= {1'b0, dvsr_reg});

    assign tgt     = dsh_reg[LEN_W-1:0];
    assign tgt_off = tgt - lo_len_reg;
    assign seg_len = hi_len_reg - lo_len_reg;

    always_comb
    begin
        case (c_reg)
            COORD_X: begin lp_a = lo_x_reg; lp_b = hi_x_reg; end
            COORD_Y: begin lp_a = lo_y_reg; lp_b = hi_y_reg; end
            COORD_Z: begin lp_a = lo_z_reg; lp_b = hi_z_reg; end
            default: begin lp_a = lo_x_reg; lp_b = hi_x_reg; end
        endcase
    end

    assign lp_diff = MW'(lp_b) - MW'(lp_a);
    assign lp_mag  = lp_diff[MW-1] ? MW'(-lp_diff) : MW'(lp_diff);
    assign lp_new  = lp_diff[MW-1] ? lp_a - CW'(dsh_reg[MW-1:0])
                                   : lp_a + CW'(dsh_reg[MW-1:0]);
    assign msum    = (LEN_W+1)'(prd_reg[P_W-1:MW]) + (LEN_W+1)'(prd_reg[0] ? num_reg : '0);

    always_comb
    begin
        if (oc_reg < OC_W'(2))
        begin
            cnt_clamp = OC_W'(2);
        end
        else if (oc_reg > OC_W'(MAX_OUTPUTS))
        begin
            cnt_clamp = OC_W'(MAX_OUTPUTS);
        end
        else
        begin
            cnt_clamp = oc_reg;
        end
    end

    always_comb
    begin
        case (c_reg)
            COORD_X: c_next = COORD_Y;
            COORD_Y: c_next = COORD_Z;
            default: c_next = COORD_X;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.accept && !full)
        begin
            x_mem[wr_addr] <= CW'(points.point_x);
            y_mem[wr_addr] <= CW'(points.point_y);
            z_mem[wr_addr] <= CW'(points.point_z);
        end
        if (cmd.len_write)
        begin
            len_mem[wr_addr] <= new_len;
        end
        rd_x_reg   <= x_mem[rd_addr];
        rd_y_reg   <= y_mem[rd_addr];
        rd_z_reg   <= z_mem[rd_addr];
        rd_len_reg <= len_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            oc_reg        <= OC_RESET;
            step_reg      <= '0;
            k_reg         <= '0;
            cnt_reg       <= OC_W'(2);
            idx_reg       <= '0;
            c_reg         <= COORD_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                oc_reg <= cfg.output_count;
            end
            if (cmd.accept)
            begin
                last_reg <= points.last_point;
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.len_write)
            begin
                count_reg <= count_reg + NW'(1);
            end
            if (cmd.run_end)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.root_load || cmd.mul_load || cmd.ldiv_load)
            begin
                step_reg <= CNT_W'(MW);
            end
            else if (cmd.tdiv_load)
            begin
                step_reg <= CNT_W'(LEN_W);
            end
            else if (cmd.root_step || cmd.div_step || cmd.mul_step)
            begin
                step_reg <= step_reg - CNT_W'(1);
            end
            if (cmd.emit_start)
            begin
                k_reg   <= '0;
                cnt_reg <= cnt_clamp;
                idx_reg <= '0;
            end
            if (cmd.advance)
            begin
                idx_reg <= idx_reg + PW'(1);
            end
            if (cmd.put)
            begin
                k_reg <= k_reg + OC_W'(1);
            end
            if (cmd.lerp_load)
            begin
                c_reg <= COORD_X;
            end
            else if (cmd.coord_store)
            begin
                c_reg <= c_next;
            end
            if (cmd.put)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_x_reg <= CW'(points.point_x);
            cur_y_reg <= CW'(points.point_y);
            cur_z_reg <= CW'(points.point_z);
        end
        if (cmd.sq_mul)
        begin
            prod_reg <= sq_prod;
        end
        if (cmd.sum_clear)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sum_add)
        begin
            sum_reg <= sum_reg + prod_reg;
        end
        if (cmd.root_load)
        begin
            rad_reg  <= sum_reg;
            rrem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= rad_reg << 2;
            rrem_reg <= rge ? rrem_sh - rtrial : rrem_sh;
            root_reg <= {root_reg[MW-2:0], rge};
        end
        if (cmd.len_write)
        begin
            prev_len_reg <= new_len;
            prev_x_reg   <= cur_x_reg;
            prev_y_reg   <= cur_y_reg;
            prev_z_reg   <= cur_z_reg;
            if (count_reg == '0)
            begin
                first_x_reg <= cur_x_reg;
                first_y_reg <= cur_y_reg;
                first_z_reg <= cur_z_reg;
            end
        end
        if (cmd.emit_start)
        begin
            acc_reg <= '0;
        end
        else if (cmd.put)
        begin
            acc_reg <= acc_reg + ACC_W'(prev_len_reg);
        end
        if (cmd.lo_load)
        begin
            lo_x_reg   <= rd_x_reg;
            lo_y_reg   <= rd_y_reg;
            lo_z_reg   <= rd_z_reg;
            lo_len_reg <= rd_len_reg;
        end
        else if (cmd.advance)
        begin
            lo_x_reg   <= hi_x_reg;
            lo_y_reg   <= hi_y_reg;
            lo_z_reg   <= hi_z_reg;
            lo_len_reg <= hi_len_reg;
        end
        if (cmd.hi_load)
        begin
            hi_x_reg   <= rd_x_reg;
            hi_y_reg   <= rd_y_reg;
            hi_z_reg   <= rd_z_reg;
            hi_len_reg <= rd_len_reg;
        end
        if (cmd.tdiv_load)
        begin
            drem_reg <= LEN_W'(acc_reg[ACC_W-1:LEN_W]);
            dsh_reg  <= SH_W'(acc_reg[LEN_W-1:0]) << SHT_T;
            dvsr_reg <= LEN_W'(cnt_reg - OC_W'(1));
        end
        else if (cmd.ldiv_load)
        begin
            drem_reg <= prd_reg[P_W-1:MW];
            dsh_reg  <= SH_W'(prd_reg[MW-1:0]) << SHT_L;
            dvsr_reg <= den_reg;
        end
        else if (cmd.div_step)
        begin
            drem_reg <= dge ? LEN_W'(dtrial - {1'b0, dvsr_reg}) : LEN_W'(dtrial);
            dsh_reg  <= {dsh_reg[SH_W-2:0], dge};
        end
        if (cmd.lerp_load)
        begin
            den_reg <= seg_len;
            num_reg <= (tgt_off > seg_len) ? seg_len : tgt_off;
        end
        if (cmd.mul_load)
        begin
            prd_reg <= P_W'(lp_mag);
        end
        else if (cmd.mul_step)
        begin
            prd_reg <= {msum, prd_reg[MW-1:1]};
        end
        case (cmd.res_sel)
            RES_FIRST:
            begin
                res_x_reg <= first_x_reg;
                res_y_reg <= first_y_reg;
                res_z_reg <= first_z_reg;
            end
            RES_LAST:
            begin
                res_x_reg <= prev_x_reg;
                res_y_reg <= prev_y_reg;
                res_z_reg <= prev_z_reg;
            end
            RES_LO:
            begin
                res_x_reg <= lo_x_reg;
                res_y_reg <= lo_y_reg;
                res_z_reg <= lo_z_reg;
            end
            default:
            begin
                if (cmd.coord_store)
                begin
                    case (c_reg)
                        COORD_X: res_x_reg <= lp_new;
                        COORD_Y: res_y_reg <= lp_new;
                        COORD_Z: res_z_reg <= lp_new;
                        default: res_x_reg <= lp_new;
                    endcase
                end
            end
        endcase
        if (cmd.put)
        begin
            out_x_reg    <= IO_W'(res_x_reg);
            out_y_reg    <= IO_W'(res_y_reg);
            out_z_reg    <= IO_W'(res_z_reg);
            out_last_reg <= (k_reg == cnt_reg - OC_W'(1));
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign points.ready          = cmd.in_ready;
    assign cfg.ready             = 1'b1;
    assign results.valid         = out_valid_reg;
    assign results.out_x         = out_x_reg;
    assign results.out_y         = out_y_reg;
    assign results.out_z         = out_z_reg;
    assign results.out_last      = out_last_reg;
    assign results.overflow_flag = out_ovf_reg;

    assign status.in_valid    = points.valid;
    assign status.in_last     = points.last_point;
    assign status.full        = full;
    assign status.count_zero  = (count_reg == '0);
    assign status.last_held   = last_reg;
    assign status.step_last   = (step_reg == CNT_W'(1));
    assign status.k_zero      = (k_reg == '0);
    assign status.k_last      = (k_reg == cnt_reg - OC_W'(1));
    assign status.n_one       = (count_reg == NW'(1));
    assign status.can_advance = (({1'b0, idx_reg} + NW'(2)) < count_reg) && (hi_len_reg < tgt);
    assign status.seg_zero    = (hi_len_reg == lo_len_reg);
    assign status.coord_last  = (c_reg == COORD_Z);
    assign status.slot_free   = !out_valid_reg || results.ready;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_put_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |-> status.slot_free)
        else $error("result written over an unaccepted item");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_start |=> (cnt_reg >= OC_W'(2) && cnt_reg <= OC_W'(MAX_OUTPUTS)))
        else $error("output count outside clamp range");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |=> (({1'b0, idx_reg} + NW'(1)) < count_reg))
        else $error("segment search ran past last segment");

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |-> (k_reg < cnt_reg))
        else $error("more results than output count");

endmodule

`default_nettype wire

// ===== sv/polyline_arc_length_resampler.sv =====
// Top level of the polyline arc-length resampler: sequencer plus datapath.
// Depends on parl_pkg, the three channel interfaces, parl_ctrl and parl_dpath.
//
// Usage:
//   points  : one 3D point (signed Q16.16) per item; last_point closes the polyline.
//   cfg     : writes output_count, always ready; write only while the block is idle.
//   results : output_count (clamped to 2..MAX_OUTPUTS) evenly spaced points, out_last on the final one,
//             overflow_flag when points beyond MAX_POINTS were dropped.
// Load: the first point of a run is stored at once; every later point has its
//   coordinate differences squared and summed, then the bit-serial square
//   root of the segment length taken. points.ready is high only between items.
// Emit: end points are copied from the stored first or last point; a middle
//   point needs the target division and three multiply/divide passes, one per
//   coordinate, plus a search step for each segment skipped.
//   A zero-length segment skips the passes.
// Stall: one output register holds each result; emission pauses while it is
//   full and results.ready is low. Input is taken again once the final result
//   sits in that register.
// Reset: the stored point count and the overflow mark clear, output_count
//   returns to 2; the stores themselves are not cleared.
`default_nettype none

module polyline_arc_length_resampler import parl_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    parl_point_if.sink     points,
    parl_cfg_if.sink       cfg,
    parl_result_if.source  results
);

    ctl_cmd_t    cmd;
    ctl_status_t status;

    parl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    parl_dpath #(
        .MAX_POINTS  (MAX_POINTS),
        .MAX_OUTPUTS (MAX_OUTPUTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (points),
        .results (results),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

`default_nettype wire
